>>> rtl/core/rcsfp_pkg.sv
package rcsfp_pkg;

   // frame layout
   localparam int unsigned FRAME_LEN       = 16;
   localparam int unsigned POS_W           = 4;
   localparam int unsigned MAX_CHANNELS_DEF = 16;

   // accepted bind-type bytes
   localparam logic [7:0] BIND_12         = 8'h12;
   localparam logic [7:0] BIND_A2         = 8'ha2;
   localparam logic [7:0] BIND_B2         = 8'hb2;

   // channel word high-byte fields
   localparam logic [7:0] HIGH_INDEX_MASK = 8'b0111_1000;
   localparam logic [7:0] HIGH_VALUE_MASK = 8'b0000_0111;

   localparam logic [15:0] WINDOW_RESET   = 16'd100;
   localparam logic [15:0] TICKS_MAX      = 16'hffff;

   // item kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_BIND  = 2'd1,
      ERR_INDEX = 2'd2
   } frame_error_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic            channel_valid;
      logic [3:0]      channel_index;
      logic [10:0]     channel_value;
      logic            frame_done;
      frame_error_type frame_error;
      logic [7:0]      error_count;
      logic [7:0]      bind_type;
      logic            connected;
   } rsp_type;

   function automatic logic bind_ok(input logic [7:0] b);
      return (b == BIND_12) || (b == BIND_A2) || (b == BIND_B2);
   endfunction

endpackage

>>> rtl/core/rc_satellite_frame_parser.sv
// channel  dir  handshake           payload
// req      in   req_valid/req_stall  rcsfp_pkg::req_type (cmd, data_byte)
// rsp      out  rsp_valid/rsp_stall  rcsfp_pkg::rsp_type (channel word, frame status)
// csr      in   csr_write_enable     csr_write_data = connect_window
//
// one result beat per request beat, registered and presented in the cycle after the request is taken
// a new request is taken every cycle while the result register is free or draining
// req_stall follows rsp_stall only while a result beat is held in the output register
// synchronous active-high reset: parser waits for an error-count byte, link disconnected,
//   connect window back to 100 ticks
module rc_satellite_frame_parser #(
   parameter int unsigned MAX_CHANNELS = rcsfp_pkg::MAX_CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  rcsfp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rcsfp_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);

   localparam int unsigned PW = rcsfp_pkg::POS_W;
   localparam logic [PW-1:0] POS_LAST = PW'(rcsfp_pkg::FRAME_LEN - 1);
   localparam logic [4:0] CH_LIMIT = 5'(MAX_CHANNELS);

   // parser state
   logic [PW-1:0]      pos_ff, pos_in;
   logic [6:0]         pending_ff, pending_in;
   logic [7:0]         err_cnt_ff, err_cnt_in;
   logic [7:0]         bind_ff, bind_in;
   logic [15:0]        ticks_ff, ticks_in;
   logic [15:0]        window_ff;

   // output register
   logic               rsp_valid_ff;
   rcsfp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic               accept;
   logic [3:0]         byte_index;

   // held result blocks new beats only while downstream stalls
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign byte_index = 4'((req_data.data_byte & rcsfp_pkg::HIGH_INDEX_MASK) >> 3);

   always_comb begin
      pos_in      = pos_ff;
      pending_in  = pending_ff;
      err_cnt_in  = err_cnt_ff;
      bind_in     = bind_ff;
      ticks_in    = ticks_ff;
      rsp_data_in = '0;
      rsp_data_in.frame_error = rcsfp_pkg::ERR_NONE;

      if (req_data.cmd == rcsfp_pkg::CMD_TICK) begin
         // saturating millisecond counter
         if (ticks_ff != rcsfp_pkg::TICKS_MAX) begin
            ticks_in = ticks_ff + 16'd1;
         end
      end else if (pos_ff == '0) begin
         err_cnt_in = req_data.data_byte;
         pos_in     = PW'(1);
      end else if (pos_ff == PW'(1)) begin
         // bind byte is kept even when rejected
         bind_in = req_data.data_byte;
         if (rcsfp_pkg::bind_ok(req_data.data_byte)) begin
            pos_in = PW'(2);
         end else begin
            rsp_data_in.frame_error = rcsfp_pkg::ERR_BIND;
            pos_in = '0;
         end
      end else if (!pos_ff[0]) begin
         // high byte of a channel word
         if ({1'b0, byte_index} < CH_LIMIT) begin
            pending_in = req_data.data_byte[6:0];
            pos_in     = pos_ff + PW'(1);
         end else begin
            rsp_data_in.frame_error = rcsfp_pkg::ERR_INDEX;
            pos_in = '0;
         end
      end else begin
         // low byte completes the word
         rsp_data_in.channel_valid = 1'b1;
         rsp_data_in.channel_index = pending_ff[6:3];
         rsp_data_in.channel_value = {pending_ff[2:0], req_data.data_byte};
         if (pos_ff == POS_LAST) begin
            rsp_data_in.frame_done = 1'b1;
            ticks_in = '0;
            pos_in   = '0;
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end

      rsp_data_in.error_count = err_cnt_in;
      rsp_data_in.bind_type   = bind_in;
      rsp_data_in.connected   = ticks_in < window_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pending_ff   <= '0;
         err_cnt_ff   <= '0;
         bind_ff      <= '0;
         ticks_ff     <= rcsfp_pkg::TICKS_MAX;
         window_ff    <= rcsfp_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         if (accept) begin
            pos_ff       <= pos_in;
            pending_ff   <= pending_in;
            err_cnt_ff   <= err_cnt_in;
            bind_ff      <= bind_in;
            ticks_ff     <= ticks_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with empty output register");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat produced no result");

   a_done_has_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_done) |-> rsp_data_ff.channel_valid)
      else $error("frame done without a completed channel word");

   a_error_resyncs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.frame_error != rcsfp_pkg::ERR_NONE)) |-> (pos_ff == '0))
      else $error("parser did not resynchronize after a frame error");
`endif

endmodule

>>> sim/tb_rc_satellite_frame_parser.sv
`timescale 1ns / 100ps

module tb_rc_satellite_frame_parser;

   // dut ports, all inputs known from time zero
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   rcsfp_pkg::req_type req_data         = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   rcsfp_pkg::rsp_type rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [15:0]        csr_write_data   = '0;

   // mirror of the parser state, advanced once per accepted request beat
   logic [4:0]  frame_pos;
   logic [6:0]  held_high;
   logic [7:0]  last_err_count;
   logic [7:0]  last_bind;
   logic [15:0] tick_count;
   logic [15:0] link_window;

   // channel results still owed by the dut, oldest first
   rcsfp_pkg::rsp_type owed_rsp_q[$];

   // idle controls shared between the stimulus and the result side
   bit          req_quiet  = 1'b0;
   bit          rsp_quiet  = 1'b0;
   int          hold_left  = 0;

   // bookkeeping for the summary
   int          mismatches   = 0;
   int          bytes_sent   = 0;
   int          ticks_sent   = 0;
   int          words_seen   = 0;
   int          frames_seen  = 0;
   int          bind_rejects = 0;
   int          windows_used = 0;

   rc_satellite_frame_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the handshake locks up
   initial begin
      #2_000_000;
      $display("timeout: parser stopped making progress");
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // frame parsing prediction
   // ------------------------------------------------------------------

   function automatic rcsfp_pkg::rsp_type parse_beat(input rcsfp_pkg::req_type beat);
      rcsfp_pkg::rsp_type r;
      logic [7:0]         b;
      b = beat.data_byte;
      r = '0;
      r.frame_error = rcsfp_pkg::ERR_NONE;
      if (beat.cmd == rcsfp_pkg::CMD_TICK) begin
         // tick counter saturates, parser position untouched
         if (tick_count != rcsfp_pkg::TICKS_MAX) tick_count = tick_count + 16'd1;
      end else if (frame_pos == 5'd0) begin
         last_err_count = b;
         frame_pos = 5'd1;
      end else if (frame_pos == 5'd1) begin
         // a rejected bind byte is still latched
         last_bind = b;
         if (b == rcsfp_pkg::BIND_12 || b == rcsfp_pkg::BIND_A2 ||
             b == rcsfp_pkg::BIND_B2) begin
            frame_pos = 5'd2;
         end else begin
            r.frame_error = rcsfp_pkg::ERR_BIND;
            frame_pos = 5'd0;
         end
      end else if (frame_pos[0] == 1'b0) begin
         // high byte of a word, bit 7 ignored
         if (b[6:3] < rcsfp_pkg::MAX_CHANNELS_DEF) begin
            held_high = b[6:0];
            frame_pos = frame_pos + 5'd1;
         end else begin
            r.frame_error = rcsfp_pkg::ERR_INDEX;
            frame_pos = 5'd0;
         end
      end else begin
         // low byte completes a word
         r.channel_valid = 1'b1;
         r.channel_index = held_high[6:3];
         r.channel_value = {held_high[2:0], b};
         if (frame_pos >= rcsfp_pkg::FRAME_LEN - 1) begin
            r.frame_done = 1'b1;
            tick_count = '0;
            frame_pos = 5'd0;
         end else begin
            frame_pos = frame_pos + 5'd1;
         end
      end
      r.error_count = last_err_count;
      r.bind_type   = last_bind;
      r.connected   = (tick_count < link_window);
      return r;
   endfunction

   function automatic string beat_text(input rcsfp_pkg::rsp_type r);
      return $sformatf("word=%0b idx=%0d val=%0d done=%0b err=%0d cnt=%02h bind=%02h conn=%0b",
                       r.channel_valid, r.channel_index, r.channel_value, r.frame_done,
                       r.frame_error, r.error_count, r.bind_type, r.connected);
   endfunction

   // ------------------------------------------------------------------
   // result side: checks every taken beat, then picks next cycle's stall
   // ------------------------------------------------------------------

   always @(posedge clock) begin : rsp_side
      rcsfp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result beat with nothing owed: %s", $realtime,
                           beat_text(rsp_data));
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: mismatch expected %s", $realtime, beat_text(want));
                     $display("%0t:          actual   %s", $realtime, beat_text(rsp_data));
                  end
               end
               if (want.channel_valid) words_seen++;
               if (want.frame_done) frames_seen++;
               if (want.frame_error == rcsfp_pkg::ERR_BIND) bind_rejects++;
            end
         end
         // long hold-off counted here, otherwise random stalls
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !rsp_quiet && ($urandom_range(99) < 22);
         end
      end
   end

   // ------------------------------------------------------------------
   // request side helpers
   // ------------------------------------------------------------------

   // one request beat, optional random gap first, valid left high on return
   task automatic send_beat(input logic cmd, input logic [7:0] b);
      rcsfp_pkg::req_type beat;
      beat.cmd       = cmd;
      beat.data_byte = b;
      if (!req_quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      owed_rsp_q.push_back(parse_beat(beat));
      if (cmd == rcsfp_pkg::CMD_TICK) ticks_sent++;
      else bytes_sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(rcsfp_pkg::CMD_TICK, 8'($urandom_range(255)));
   endtask

   function automatic logic [7:0] good_bind();
      case ($urandom_range(2))
         0:       return rcsfp_pkg::BIND_12;
         1:       return rcsfp_pkg::BIND_A2;
         default: return rcsfp_pkg::BIND_B2;
      endcase
   endfunction

   // frame with random content; nbytes < 16 cuts it short
   task automatic send_frame(input logic [7:0] bind_byte, input int nbytes, input int tick_pct);
      int i;
      for (i = 0; i < nbytes; i++) begin
         if ($urandom_range(99) < tick_pct)
            send_beat(rcsfp_pkg::CMD_TICK, 8'($urandom_range(255)));
         if (i == 1) send_beat(rcsfp_pkg::CMD_BYTE, bind_byte);
         else        send_beat(rcsfp_pkg::CMD_BYTE, 8'($urandom_range(255)));
      end
   endtask

   // random bytes until the parser expects an error-count byte again
   task automatic resync();
      while (frame_pos != 5'd0) send_beat(rcsfp_pkg::CMD_BYTE, 8'($urandom_range(255)));
   endtask

   // window write only with the pipe empty
   task automatic write_window(input logic [15:0] w);
      req_valid <= 1'b0;
      while (owed_rsp_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= w;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      link_window = w;
      windows_used++;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset window, saturated counter, rejected bind, then one frame with extreme words
   task automatic test_directed_frame();
      send_beat(rcsfp_pkg::CMD_TICK, 8'h00);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h00);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h13);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'hff);
      send_beat(rcsfp_pkg::CMD_BYTE, rcsfp_pkg::BIND_B2);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'hff);   // bit 7 set, index 15, top bits all ones
      send_beat(rcsfp_pkg::CMD_BYTE, 8'hff);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h00);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h00);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h80);   // bit 7 alone
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h55);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h7f);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'haa);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h38);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h01);
      send_beat(rcsfp_pkg::CMD_TICK, 8'hff);   // tick in the middle of a frame
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h47);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h80);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h0a);
      send_beat(rcsfp_pkg::CMD_BYTE, 8'h33);
      send_beat(rcsfp_pkg::CMD_TICK, 8'h00);
   endtask

   // zero window never connects, then the one-tick, widest and three-tick windows
   task automatic test_window_extremes();
      write_window(16'd0);
      send_beat(rcsfp_pkg::CMD_TICK, 8'h00);
      write_window(16'd1);
      send_beat(rcsfp_pkg::CMD_TICK, 8'h00);
      write_window(16'hffff);
      send_beat(rcsfp_pkg::CMD_TICK, 8'h00);
      write_window(16'd3);
      send_beat(rcsfp_pkg::CMD_TICK, 8'h00);
   endtask

   // back-to-back beats on both sides
   task automatic test_no_idle_stretch();
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      repeat (3) send_frame(good_bind(), 16, 5);
      send_ticks(4);
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   // receiver holds off while requests keep coming, so the parser backs up
   task automatic test_backpressure();
      req_quiet = 1'b1;
      hold_left = 60;
      send_frame(good_bind(), 16, 0);
      send_ticks(20);
      req_quiet = 1'b0;
   endtask

   // mostly well-formed frames with random content, some broken ones and noise
   task automatic test_random_stream();
      logic [15:0] phase_window[6];
      int          p;
      int          start;
      int          roll;
      phase_window = '{16'd1, 16'd3, 16'd12, 16'd40, 16'hffff,
                       16'($urandom_range(1, 65535))};
      for (p = 0; p < 6; p++) begin
         write_window(phase_window[p]);
         start = bytes_sent + ticks_sent;
         while (bytes_sent + ticks_sent - start < 60) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
               send_frame(good_bind(), 16, 8);
            end else if (roll < 80) begin
               // any bind byte, mostly a rejected one
               send_frame(8'($urandom_range(255)), 16, 8);
               resync();
            end else if (roll < 90) begin
               send_frame(good_bind(), $urandom_range(1, 15), 8);
               resync();
            end else begin
               repeat ($urandom_range(1, 6))
                  send_beat(rcsfp_pkg::CMD_BYTE, 8'($urandom_range(255)));
               resync();
            end
            // tick bursts let the link drop out for the short windows
            if ($urandom_range(99) < 50) send_ticks($urandom_range(1, 20));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      int guard;
      frame_pos      = '0;
      held_high      = '0;
      last_err_count = '0;
      last_bind      = '0;
      tick_count     = rcsfp_pkg::TICKS_MAX;
      link_window    = rcsfp_pkg::WINDOW_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_frame();
      test_window_extremes();
      test_no_idle_stretch();
      test_backpressure();
      test_random_stream();

      // drain, then let the registered result path settle
      req_valid <= 1'b0;
      guard = 0;
      while (owed_rsp_q.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (owed_rsp_q.size() != 0) begin
         mismatches++;
         $display("%0d result beats never arrived", owed_rsp_q.size());
      end

      $display("sent %0d serial bytes and %0d ticks over %0d window settings",
               bytes_sent, ticks_sent, windows_used);
      $display("saw %0d channel words, %0d complete frames, %0d rejected bind bytes",
               words_seen, frames_seen, bind_rejects);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/rcsfp_pkg.sv
rtl/core/rc_satellite_frame_parser.sv
sim/tb_rc_satellite_frame_parser.sv
